[hdl/elgamal_encrypt_decrypt_assert.svh]
// ----------------------------------------------------------------------------
// elgamal_encrypt_decrypt_assert
// Assertion macros for the ElGamal block.
// ----------------------------------------------------------------------------
`ifndef ELGAMAL_ENCRYPT_DECRYPT_ASSERT_SVH
`define ELGAMAL_ENCRYPT_DECRYPT_ASSERT_SVH
// implication checked every clock, off in reset
`define EG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define EG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[hdl/eg_pkg.sv]
// ----------------------------------------------------------------------------
// eg_pkg
// Shared constants and types of the ElGamal block.
// ----------------------------------------------------------------------------
package eg_pkg;
    localparam int MOD_BITS_DEF = 31;
    localparam int CFG_IDX_W    = 2;
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GENERATOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PUBKEY    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SECKEY    = 2'd3;
    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;
    localparam int RST_MODULUS   = 23;
    localparam int RST_GENERATOR = 4;
    localparam int RST_PUBKEY    = 1;
    localparam int RST_SECKEY    = 0;

    // request to the modular multiply unit
    typedef struct packed {
        logic start;
    } t_mul_ctl;
    typedef struct packed {
        logic done;
    } t_mul_sts;
endpackage

[hdl/eg_if.sv]
// ----------------------------------------------------------------------------
// eg_in_if / eg_out_if
// Valid/ready channels carrying input and result items.
// ----------------------------------------------------------------------------
interface eg_in_if #(parameter int W = 31);
    logic         valid;
    logic         ready;
    logic         opcode;
    logic [W-1:0] message;
    logic [W-1:0] random_exponent;
    logic [W-1:0] cipher_part_one;
    logic [W-1:0] cipher_part_two;
    modport source (output valid, opcode, message, random_exponent,
                    cipher_part_one, cipher_part_two, input ready);
    modport sink (input valid, opcode, message, random_exponent,
                  cipher_part_one, cipher_part_two, output ready);
endinterface

interface eg_out_if #(parameter int W = 31);
    logic         valid;
    logic         ready;
    logic [W-1:0] out_first;
    logic [W-1:0] out_second;
    logic [W-1:0] recovered;
    logic         status;
    modport source (output valid, out_first, out_second, recovered, status,
                    input ready);
    modport sink (input valid, out_first, out_second, recovered, status,
                  output ready);
endinterface

[hdl/eg_modmul.sv]
// ----------------------------------------------------------------------------
// eg_modmul
// Shift-and-add modular multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module eg_modmul
    import eg_pkg::*;
#(
    parameter int MOD_BITS = MOD_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_mul_ctl            i_ctl,
    input  logic [MOD_BITS-1:0] i_a,
    input  logic [MOD_BITS-1:0] i_b,
    input  logic [MOD_BITS-1:0] i_p,
    output t_mul_sts            o_sts,
    output logic [MOD_BITS-1:0] o_prod
);
    localparam int CW = $clog2(MOD_BITS + 1);

    logic                r_busy;
    logic                r_done;
    logic [CW-1:0]       r_cnt;
    logic [MOD_BITS-1:0] r_a, r_b, r_acc;
    logic [MOD_BITS:0]   w_sum_acc, w_sum_dbl;
    logic [MOD_BITS-1:0] n_acc, n_a;

    // a and acc stay below p, so one compare-subtract reduces each sum
    always_comb begin
        w_sum_acc = {1'b0, r_acc} + {1'b0, r_a};
        w_sum_dbl = {1'b0, r_a} + {1'b0, r_a};
        n_acc = r_acc;
        if (r_b[0]) begin
            n_acc = (w_sum_acc >= {1'b0, i_p}) ?
                MOD_BITS'(w_sum_acc - {1'b0, i_p}) : w_sum_acc[MOD_BITS-1:0];
        end
        n_a = (w_sum_dbl >= {1'b0, i_p}) ?
            MOD_BITS'(w_sum_dbl - {1'b0, i_p}) : w_sum_dbl[MOD_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_ctl.start && r_busy && (r_cnt == CW'(MOD_BITS - 1));
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_a    <= i_a;
                r_b    <= i_b;
                r_acc  <= '0;
            end else if (r_busy) begin
                r_acc <= n_acc;
                r_a   <= n_a;
                r_b   <= r_b >> 1;
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(MOD_BITS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_sts.done = r_done;
    assign o_prod     = r_acc;

`include "elgamal_encrypt_decrypt_assert.svh"
    `EG_ASSERT_NXT(a_done_after_busy, i_clk, i_rst_n, r_done, !r_busy)
    `EG_ASSERT_IMP(a_acc_below_p, i_clk, i_rst_n, r_busy && i_p >= 2, r_acc < i_p)
    `EG_ASSERT_IMP(a_no_start_busy, i_clk, i_rst_n, i_ctl.start, !r_busy)
endmodule

[hdl/elgamal_encrypt_decrypt.sv]
// ----------------------------------------------------------------------------
// elgamal_encrypt_decrypt
// ElGamal encrypt/decrypt over a prime modulus with one shared modmul.
// ----------------------------------------------------------------------------
// channel   dir  fields
// s_in      in   opcode, message, random_exponent, cipher_part_one/two
// m_out     out  out_first, out_second, recovered, status
// cfg       in   i_cfg_we, i_cfg_idx, i_cfg_data
//
// An exponent bit costs a squaring, and one more multiply when the bit is set.
// Encrypt: three reductions, g^r, pk^r, final multiply; decrypt: two
// reductions, c1^sk, x^(p-2), final multiply. A modulus below two goes
// straight to the result.
// Input is ready only in idle; a held result blocks the next item.
// Reset is synchronous.
// ----------------------------------------------------------------------------
module elgamal_encrypt_decrypt
    import eg_pkg::*;
#(
    parameter int MOD_BITS = MOD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [MOD_BITS-1:0]  i_cfg_data,
    eg_in_if.sink                s_in,
    eg_out_if.source             m_out
);
    typedef enum logic [3:0] {
        S_IDLE, S_RED, S_RED_W, S_SETUP, S_EXP, S_EXP_W1, S_EXP_W2,
        S_NEXT, S_FIN, S_FIN_W, S_OUT
    } t_state;

    // phases of the job
    typedef enum logic [2:0] {
        PH_RED_A, PH_RED_B, PH_RED_C, PH_POW1, PH_POW2, PH_MUL
    } t_phase;

    t_state              r_state;
    t_phase              r_ph;
    logic [MOD_BITS-1:0] r_p, r_g, r_pk, r_sk;
    logic                r_op;
    logic [MOD_BITS-1:0] r_m, r_r, r_c1, r_c2;
    logic [MOD_BITS-1:0] r_base, r_e, r_acc, r_t1, r_t2;
    logic [MOD_BITS-1:0] r_first, r_second, r_rec;
    logic                r_status;
    logic [MOD_BITS-1:0] r_ma, r_mb;
    t_mul_ctl            r_ctl;
    logic                n_start;
    t_mul_sts            w_sts;
    logic [MOD_BITS-1:0] w_prod;
    logic [MOD_BITS-1:0] w_red_in;
    logic [MOD_BITS-1:0] w_one;

    eg_modmul #(.MOD_BITS(MOD_BITS)) u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (r_ctl),
        .i_a    (r_ma),
        .i_b    (r_mb),
        .i_p    (r_p),
        .o_sts  (w_sts),
        .o_prod (w_prod)
    );

    // x mod p is formed as 1*x through the modmul; 1 < p, x takes any value
    assign w_one = MOD_BITS'(1);

    always_comb begin
        unique case (r_ph)
            PH_RED_A: w_red_in = (r_op == OP_DECRYPT) ? r_c1 : r_m;
            PH_RED_B: w_red_in = (r_op == OP_DECRYPT) ? r_c2 : r_g;
            PH_RED_C: w_red_in = r_pk;
            default:  w_red_in = r_m;
        endcase
    end

    // modmul start request, registered below
    always_comb begin
        n_start = (r_state == S_RED) ||
                  (r_state == S_EXP && r_e != '0) ||
                  (r_state == S_EXP_W1 && w_sts.done) ||
                  (r_state == S_NEXT && r_ph != PH_POW1);
    end

    assign s_in.ready       = (r_state == S_IDLE);
    assign m_out.valid      = (r_state == S_OUT);
    assign m_out.out_first  = r_first;
    assign m_out.out_second = r_second;
    assign m_out.recovered  = r_rec;
    assign m_out.status     = r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ph    <= PH_RED_A;
            r_ctl   <= '0;
            r_p     <= MOD_BITS'(RST_MODULUS);
            r_g     <= MOD_BITS'(RST_GENERATOR);
            r_pk    <= MOD_BITS'(RST_PUBKEY);
            r_sk    <= MOD_BITS'(RST_SECKEY);
        end else begin
            r_ctl.start <= n_start;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_MODULUS:   r_p  <= i_cfg_data;
                    REG_GENERATOR: r_g  <= i_cfg_data;
                    REG_PUBKEY:    r_pk <= i_cfg_data;
                    REG_SECKEY:    r_sk <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_in.valid) begin
                        r_op     <= s_in.opcode;
                        r_m      <= s_in.message;
                        r_r      <= s_in.random_exponent;
                        r_c1     <= s_in.cipher_part_one;
                        r_c2     <= s_in.cipher_part_two;
                        r_first  <= '0;
                        r_second <= '0;
                        r_rec    <= '0;
                        r_status <= 1'b0;
                        r_ph     <= PH_RED_A;
                        r_state  <= (r_p < MOD_BITS'(2)) ? S_OUT : S_RED;
                    end
                end
                S_RED: begin
                    r_ma    <= w_one;
                    r_mb    <= w_red_in;
                    r_state <= S_RED_W;
                end
                S_RED_W: begin
                    if (w_sts.done) begin
                        unique case (r_ph)
                            PH_RED_A: begin
                                if (r_op == OP_DECRYPT) r_c1 <= w_prod;
                                else r_m <= w_prod;
                                r_ph <= PH_RED_B;
                                r_state <= S_RED;
                            end
                            PH_RED_B: begin
                                if (r_op == OP_DECRYPT) begin
                                    r_c2 <= w_prod;
                                    if (r_c1 == '0) begin
                                        r_status <= 1'b1;
                                        r_state  <= S_OUT;
                                    end else begin
                                        r_base  <= r_c1;
                                        r_e     <= r_sk;
                                        r_ph    <= PH_POW1;
                                        r_state <= S_SETUP;
                                    end
                                end else begin
                                    r_t1    <= w_prod;
                                    r_ph    <= PH_RED_C;
                                    r_state <= S_RED;
                                end
                            end
                            default: begin
                                r_t2    <= w_prod;
                                r_base  <= r_t1;
                                r_e     <= r_r;
                                r_ph    <= PH_POW1;
                                r_state <= S_SETUP;
                            end
                        endcase
                    end
                end
                S_SETUP: begin
                    r_acc   <= MOD_BITS'(1);
                    r_state <= S_EXP;
                end
                S_EXP: begin
                    if (r_e == '0) begin
                        r_state <= S_NEXT;
                    end else if (r_e[0]) begin
                        r_ma    <= r_acc;
                        r_mb    <= r_base;
                        r_state <= S_EXP_W1;
                    end else begin
                        r_ma    <= r_base;
                        r_mb    <= r_base;
                        r_state <= S_EXP_W2;
                    end
                end
                S_EXP_W1: begin
                    if (w_sts.done) begin
                        r_acc   <= w_prod;
                        r_ma    <= r_base;
                        r_mb    <= r_base;
                        r_state <= S_EXP_W2;
                    end
                end
                S_EXP_W2: begin
                    if (w_sts.done) begin
                        r_base  <= w_prod;
                        r_e     <= r_e >> 1;
                        r_state <= S_EXP;
                    end
                end
                S_NEXT: begin
                    if (r_ph == PH_POW1) begin
                        r_ph <= PH_POW2;
                        if (r_op == OP_DECRYPT) begin
                            r_base <= r_acc;
                            r_e    <= r_p - MOD_BITS'(2);
                        end else begin
                            r_first <= r_acc;
                            r_base  <= r_t2;
                            r_e     <= r_r;
                        end
                        r_state <= S_SETUP;
                    end else begin
                        r_ph    <= PH_MUL;
                        r_ma    <= (r_op == OP_DECRYPT) ? r_c2 : r_m;
                        r_mb    <= r_acc;
                        r_state <= S_FIN_W;
                    end
                end
                S_FIN_W: begin
                    if (w_sts.done) begin
                        if (r_op == OP_DECRYPT) r_rec <= w_prod;
                        else r_second <= w_prod;
                        r_state <= S_OUT;
                    end
                end
                S_FIN: r_state <= S_OUT;
                S_OUT: begin
                    if (m_out.ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`include "elgamal_encrypt_decrypt_assert.svh"
    `EG_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, s_in.ready, !m_out.valid)
    `EG_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_out.valid && !m_out.ready, m_out.valid && $stable(r_first) && $stable(r_rec))
    `EG_ASSERT_IMP(a_status_dec, i_clk, i_rst_n, m_out.valid && m_out.status, r_op == OP_DECRYPT && r_rec == '0)
endmodule
